>>> rtl/core/assert_macros.svh
// Assertion macros for the tangent basis block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TTB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TTB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TTB_ASSERT(label, clk, rst_n, prop)
`define TTB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/ttb_pkg.sv
// Shared types and constants for the tangent basis block.
package ttb_pkg;

    localparam int COORD_W    = 16;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int PROD_W     = 2 * DELTA_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int RES_W      = 32;
    localparam int FRAC_SHIFT = 20;
    localparam int INT_BITS   = RES_W - 1 - FRAC_SHIFT;
    localparam int NUM_COMP   = 6;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [RES_W-1:0] tangent_x;
        logic signed [RES_W-1:0] tangent_y;
        logic signed [RES_W-1:0] tangent_z;
        logic signed [RES_W-1:0] bitangent_x;
        logic signed [RES_W-1:0] bitangent_y;
        logic signed [RES_W-1:0] bitangent_z;
        logic                    degenerate;
    } basis_t;

    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      sub;
        logic signed [DELTA_W-1:0] a;
        logic signed [DELTA_W-1:0] b;
    } mac_op_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic signed [ACC_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [RES_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> rtl/core/ttb_mac.sv
// Shared multiply-accumulate unit: registered product, then signed add or subtract.
module ttb_mac
    import ttb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_op_t                 op,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pend_reg;
    logic                     first_reg;
    logic                     sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            pend_reg  <= op.valid;
            first_reg <= op.first;
            sub_reg   <= op.sub;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg <= $signed(op.a) * $signed(op.b);
        end
        if (pend_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        base     = first_reg ? '0 : acc_reg;
        prod_ext = {prod_reg[PROD_W-1], prod_reg};
        acc_next = sub_reg ? (base - prod_ext) : (base + prod_ext);
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/ttb_div.sv
// Radix-2 restoring divider for num * 2^20 / den with saturation to 32 bits.
module ttb_div
    import ttb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int MAG_W = ACC_W;
    localparam int STEPS = RES_W - 1;
    localparam int CNT_W = $clog2(STEPS);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

    logic [1:0]        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  num_mag_reg;
    logic [MAG_W-1:0]  den_mag_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [STEPS-1:0]  bits_reg;
    logic [STEPS-1:0]  q_reg;
    logic [RES_W-1:0]  quot_reg;

    logic [MAG_W-1:0]  num_abs;
    logic [MAG_W-1:0]  den_abs;
    logic              sat;
    logic [MAG_W:0]    trial;
    logic              ge;
    logic [MAG_W:0]    trial_sub;
    logic [STEPS-1:0]  q_next;
    logic [RES_W-1:0]  q_pos;

    always_comb
    begin
        num_abs   = req.num[ACC_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
        den_abs   = req.den[ACC_W-1] ? MAG_W'(-req.den) : MAG_W'(req.den);
        sat       = {{INT_BITS{1'b0}}, num_mag_reg} >= {den_mag_reg, {INT_BITS{1'b0}}};
        trial     = {rem_reg, bits_reg[STEPS-1]};
        ge        = trial >= {1'b0, den_mag_reg};
        trial_sub = trial - {1'b0, den_mag_reg};
        q_next    = {q_reg[STEPS-2:0], ge};
        q_pos     = {1'b0, q_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= D_CHK;
                    end
                end
                D_CHK:
                begin
                    cnt_reg <= '0;
                    if (sat)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    num_mag_reg <= num_abs;
                    den_mag_reg <= den_abs;
                    neg_reg     <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
                end
            end
            D_CHK:
            begin
                rem_reg  <= num_mag_reg >> INT_BITS;
                bits_reg <= {num_mag_reg[INT_BITS-1:0], {FRAC_SHIFT{1'b0}}};
                q_reg    <= '0;
                if (sat)
                begin
                    quot_reg <= neg_reg ? SAT_MIN : SAT_MAX;
                end
            end
            D_RUN:
            begin
                rem_reg  <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
                bits_reg <= bits_reg << 1;
                q_reg    <= q_next;
                quot_reg <= neg_reg ? (-q_pos) : q_pos;
            end
            default:
            begin
                q_reg <= '0;
            end
        endcase
    end

    assign rsp.busy = (state_reg != D_IDLE);
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> rtl/core/triangle_tangent_basis.sv
// Per-triangle tangent and bitangent from texture coordinates, top level.
//
// Vertices arrive on the vtx channel (valid/stall), three per triangle.
// The first two beats of a triangle are held, with vtx_stall low.
// On the third beat the block forms the deltas and works the triangle
// through one shared multiply-accumulate unit and one radix-2 divider:
// two products for the determinant, then per component two products
// and a 31-step division. A saturated component skips its division
// steps, and a zero determinant skips the components and goes straight
// to the result.
// vtx_stall is high while a triangle is being worked or waits to leave.
// One result beat per triangle leaves on the res channel (valid/stall)
// from an output register; the next triangle's vertices are taken while
// that beat waits, and a finished triangle holds until the register frees.
// A zero determinant sets degenerate and gives zero vectors.
// Reset (rst_n low) empties the vertex count and drops any pending beat.
`include "assert_macros.svh"

module triangle_tangent_basis
    import ttb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    vtx_valid,
    output logic    vtx_stall,
    input  vertex_t vtx,
    output logic    res_valid,
    input  logic    res_stall,
    output basis_t  res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_USE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [2:0] COMP_DET = 3'd0;
    localparam logic [2:0] COMP_TX  = 3'd1;
    localparam logic [2:0] COMP_TY  = 3'd2;
    localparam logic [2:0] COMP_TZ  = 3'd3;
    localparam logic [2:0] COMP_BX  = 3'd4;
    localparam logic [2:0] COMP_BY  = 3'd5;
    localparam logic [2:0] COMP_BZ  = 3'd6;

    logic [2:0]                state_reg;
    logic [1:0]                corner_slot_reg;
    logic [2:0]                comp_reg;
    logic                      term_reg;
    logic                      res_valid_reg;
    logic                      degenerate_reg;
    vertex_t                   held_reg [2];
    logic signed [DELTA_W-1:0] dp1_reg [3];
    logic signed [DELTA_W-1:0] dp2_reg [3];
    logic signed [DELTA_W-1:0] du1_reg;
    logic signed [DELTA_W-1:0] dv1_reg;
    logic signed [DELTA_W-1:0] du2_reg;
    logic signed [DELTA_W-1:0] dv2_reg;
    logic signed [ACC_W-1:0]   det_reg;
    logic signed [RES_W-1:0]   comp_res_reg [NUM_COMP];
    basis_t                    res_reg;

    logic                      vtx_accept;
    logic                      res_free;
    logic [1:0]                kk;
    logic [2:0]                slot;
    mac_op_t                   mac_op;
    logic signed [ACC_W-1:0]   acc;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    function automatic logic signed [DELTA_W-1:0] delta(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        delta = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    endfunction

    assign vtx_stall  = (state_reg != S_IDLE);
    assign vtx_accept = vtx_valid && !vtx_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign slot       = comp_reg - 3'd1;

    always_comb
    begin
        kk           = (comp_reg >= COMP_BX) ? 2'(comp_reg - COMP_BX) : 2'(comp_reg - COMP_TX);
        mac_op.valid = (state_reg == S_MUL);
        mac_op.first = !term_reg;
        mac_op.sub   = term_reg;
        unique case (comp_reg)
            COMP_DET:
            begin
                mac_op.a = term_reg ? dv1_reg : du1_reg;
                mac_op.b = term_reg ? du2_reg : dv2_reg;
            end
            COMP_TX, COMP_TY, COMP_TZ:
            begin
                mac_op.a = term_reg ? dp2_reg[kk] : dp1_reg[kk];
                mac_op.b = term_reg ? dv1_reg : dv2_reg;
            end
            COMP_BX, COMP_BY, COMP_BZ:
            begin
                mac_op.a = term_reg ? dp1_reg[kk] : dp2_reg[kk];
                mac_op.b = term_reg ? du2_reg : du1_reg;
            end
            default:
            begin
                mac_op.a = '0;
                mac_op.b = '0;
            end
        endcase
        div_req.start = (state_reg == S_USE) && (comp_reg != COMP_DET);
        div_req.num   = acc;
        div_req.den   = det_reg;
    end

    ttb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    ttb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            corner_slot_reg <= 2'd0;
            comp_reg        <= COMP_DET;
            term_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            degenerate_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (vtx_accept)
                    begin
                        if (corner_slot_reg[1])
                        begin
                            corner_slot_reg <= 2'd0;
                            comp_reg        <= COMP_DET;
                            term_reg        <= 1'b0;
                            state_reg       <= S_MUL;
                        end
                        else
                        begin
                            corner_slot_reg <= corner_slot_reg + 2'd1;
                        end
                    end
                end
                S_MUL:
                begin
                    term_reg <= !term_reg;
                    if (term_reg)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_USE;
                end
                S_USE:
                begin
                    if (comp_reg == COMP_DET)
                    begin
                        if (acc == '0)
                        begin
                            degenerate_reg <= 1'b1;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            degenerate_reg <= 1'b0;
                            comp_reg       <= COMP_TX;
                            state_reg      <= S_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (comp_reg == COMP_BZ)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_accept && !corner_slot_reg[1])
        begin
            held_reg[corner_slot_reg[0]] <= vtx;
        end
        if (vtx_accept && corner_slot_reg[1])
        begin
            dp1_reg[0] <= delta(held_reg[1].pos_x, held_reg[0].pos_x);
            dp1_reg[1] <= delta(held_reg[1].pos_y, held_reg[0].pos_y);
            dp1_reg[2] <= delta(held_reg[1].pos_z, held_reg[0].pos_z);
            dp2_reg[0] <= delta(vtx.pos_x, held_reg[0].pos_x);
            dp2_reg[1] <= delta(vtx.pos_y, held_reg[0].pos_y);
            dp2_reg[2] <= delta(vtx.pos_z, held_reg[0].pos_z);
            du1_reg    <= delta(held_reg[1].tex_u, held_reg[0].tex_u);
            dv1_reg    <= delta(held_reg[1].tex_v, held_reg[0].tex_v);
            du2_reg    <= delta(vtx.tex_u, held_reg[0].tex_u);
            dv2_reg    <= delta(vtx.tex_v, held_reg[0].tex_v);
        end
        if (state_reg == S_USE && comp_reg == COMP_DET)
        begin
            det_reg <= acc;
        end
        if (state_reg == S_DIV && div_rsp.done)
        begin
            comp_res_reg[slot] <= div_rsp.quot;
        end
        if (state_reg == S_DONE && res_free)
        begin
            res_reg.tangent_x   <= degenerate_reg ? '0 : comp_res_reg[0];
            res_reg.tangent_y   <= degenerate_reg ? '0 : comp_res_reg[1];
            res_reg.tangent_z   <= degenerate_reg ? '0 : comp_res_reg[2];
            res_reg.bitangent_x <= degenerate_reg ? '0 : comp_res_reg[3];
            res_reg.bitangent_y <= degenerate_reg ? '0 : comp_res_reg[4];
            res_reg.bitangent_z <= degenerate_reg ? '0 : comp_res_reg[5];
            res_reg.degenerate  <= degenerate_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TTB_ASSERT(a_third_vertex_starts, clk, rst_n, (vtx_accept && corner_slot_reg == 2'd2) |=> (state_reg == S_MUL))
    `TTB_ASSERT(a_div_only_in_div, clk, rst_n, div_rsp.busy |-> (state_reg == S_DIV))
    `TTB_ASSERT(a_degenerate_zero, clk, rst_n, (res_valid && res.degenerate) |-> (res[NUM_COMP*RES_W:1] == '0))
    `TTB_ASSERT_NEVER(a_corner_in_range, clk, rst_n, corner_slot_reg == 2'd3)

endmodule
